FILE: hdl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg: shared types and constants for the path MTU cache
// Table depth, opcodes, IP version codes, the IPv4-mapped key prefix, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pmc_pkg;

  // table depth; result counts are 5 bits wide, so it stays at 16
  localparam int ENTRIES = 16;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_LOWER  = 2'd1,
    OP_RAISE  = 2'd2,
    OP_PURGE  = 2'd3
  } op_e;

  localparam logic [3:0]  VER_V4 = 4'd4;
  localparam logic [3:0]  VER_V6 = 4'd6;
  localparam logic [63:0] V4_MAP_HI = 64'h0000_FFFF_0000_0000;

  // register indexes
  localparam logic [2:0] REG_MIN_V4 = 3'd0;
  localparam logic [2:0] REG_MAX_V4 = 3'd1;
  localparam logic [2:0] REG_MIN_V6 = 3'd2;
  localparam logic [2:0] REG_MAX_V6 = 3'd3;
  localparam logic [2:0] REG_DEF_TTL = 3'd4;
  localparam logic [2:0] REG_CAP = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PURGE,
    ST_EVICT,
    ST_WRITE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/path_mtu_cache.sv
// ----------------------------------------------------------------------------
// path_mtu_cache: table of path MTUs keyed by IP version and destination
// Entries live in one synchronous memory that a sequencer walks per request.
// ----------------------------------------------------------------------------
// Every request except a non-purge one with a bad version walks all ENTRIES
// memory entries, one read per cycle through the single read port; a scan walk
// matches the key, checks expiry and tracks the oldest entry, and a purge walk
// clears the valid bit of each expired entry as it passes. After the scan walk
// a lookup, lower or raise goes through the write state (preceded by the evict
// state when an insert must first drop the oldest entry) to the done state; a
// purge goes from its walk to the done state, and a bad-version lookup, lower or
// raise goes straight there. Valid bits and age ranks sit in flip-flops. The
// result waits in an output register and blocks new requests until taken, so
// the next request is accepted only after the result has been taken.
`default_nettype none

module path_mtu_cache
  import pmc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode[1:0], ip_ver[5:2], addr_hi[69:6], addr_lo[133:70],
  // mtu_value[165:134], now_time[229:166], ttl_value[261:230], zero pad
  input  wire logic [263:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[0], found[1], mtu_out[33:2], removed_count[38:34],
  // entry_total[43:39], zero pad
  output logic [47:0]       m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic        is_v6;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] mtu;
    logic [63:0] stamp;
    logic [31:0] life;
  } entry_t;

  // configuration
  logic [31:0] min_v4_q, max_v4_q, min_v6_q, max_v6_q, def_ttl_q;
  logic [4:0]  cap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_v4_q  <= 32'd68;
      max_v4_q  <= 32'd65535;
      min_v6_q  <= 32'd1280;
      max_v6_q  <= 32'd65535;
      def_ttl_q <= 32'd600000;
      cap_q     <= 5'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_V4:  min_v4_q  <= cfg_data_i;
        REG_MAX_V4:  max_v4_q  <= cfg_data_i;
        REG_MIN_V6:  min_v6_q  <= cfg_data_i;
        REG_MAX_V6:  max_v6_q  <= cfg_data_i;
        REG_DEF_TTL: def_ttl_q <= cfg_data_i;
        REG_CAP:     cap_q     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic [1:0]  op_q;
  logic        v6_q;
  logic        badver_q;
  logic [63:0] hi_q, lo_q, now_q;
  logic [31:0] mtu_q, life_q;

  logic [1:0]  in_op;
  logic [3:0]  in_ver;
  logic [63:0] in_hi, in_lo, in_now;
  logic [31:0] in_mtu, in_ttl, clamp_lo, clamp_hi, clamp_a, clamp_b;
  logic        in_v6;

  assign in_op  = s_axis_tdata[1:0];
  assign in_ver = s_axis_tdata[5:2];
  assign in_hi  = s_axis_tdata[69:6];
  assign in_lo  = s_axis_tdata[133:70];
  assign in_mtu = s_axis_tdata[165:134];
  assign in_now = s_axis_tdata[229:166];
  assign in_ttl = s_axis_tdata[261:230];
  assign in_v6  = (in_ver == VER_V6);

  always_comb begin
    clamp_lo = in_v6 ? min_v6_q : min_v4_q;
    clamp_hi = in_v6 ? max_v6_q : max_v4_q;
    clamp_a  = (in_mtu < clamp_lo) ? clamp_lo : in_mtu;
    clamp_b  = (clamp_a > clamp_hi) ? clamp_hi : clamp_a;
  end

  // memory and per-entry flags
  entry_t           mem_q [ENTRIES];
  entry_t           rd_q;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  entry_t           wr_data;
  logic [ENTRIES-1:0] valid_q;
  logic [IW-1:0]    rank_q [ENTRIES];
  logic [CW-1:0]    fill_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  // sequencer
  state_e        st_q, st_d;
  logic [CW-1:0] idx_q;   // address being issued
  logic          rdv_q;   // rd_q holds entry idx_q-1
  logic [IW-1:0] cur;
  logic          hit_q, old_ok_q;
  logic [IW-1:0] hit_idx_q, old_idx_q, free_idx_q;
  logic          free_ok_q;
  logic [63:0]   old_stamp_q;
  logic [IW-1:0] old_rank_q;
  logic [31:0]   hit_mtu_q;
  logic          hit_exp_q;
  logic [4:0]    removed_q;
  logic          out_v_q;
  logic [47:0]   out_q;

  logic          cur_exp, cur_match, cur_older;
  logic [4:0]    cap_eff;
  logic          full;

  assign cur = idx_q[IW-1:0] - IW'(1);
  assign cur_exp = (now_q < rd_q.stamp) ||
                   ((now_q - rd_q.stamp) > {32'd0, rd_q.life});
  assign cur_match = valid_q[cur] && (rd_q.is_v6 == v6_q) &&
                     (rd_q.key_hi == hi_q) && (rd_q.key_lo == lo_q);
  assign cur_older = !old_ok_q || (rd_q.stamp < old_stamp_q) ||
                     ((rd_q.stamp == old_stamp_q) && (rank_q[cur] < old_rank_q));
  assign cap_eff = (cap_q == 5'd0) ? 5'd1 :
                   ({27'd0, cap_q} > ENTRIES) ? 5'(ENTRIES) : cap_q;
  assign full = ({{(32-CW){1'b0}}, fill_q} >= {27'd0, cap_eff});

  assign s_axis_tready = (st_q == ST_IDLE) && !out_v_q;
  assign rd_addr = (st_q == ST_IDLE) ? '0 : idx_q[IW-1:0];

  logic last_rd;
  assign last_rd = rdv_q && ({{(32-CW){1'b0}}, idx_q} == ENTRIES);

  // insert into a full table needs the oldest entry dropped first
  logic evict_now;
  assign evict_now = last_rd && !hit_q && !cur_match && op_q != OP_LOOKUP && full &&
                     (old_ok_q || (valid_q[cur] && cur_older));

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        if (in_op == OP_PURGE) st_d = ST_PURGE;
        else if (in_ver != VER_V4 && in_ver != VER_V6) st_d = ST_DONE;
        else st_d = ST_SCAN;
      end
      ST_SCAN:  if (last_rd) st_d = evict_now ? ST_EVICT : ST_WRITE;
      ST_PURGE: if (last_rd) st_d = ST_DONE;
      ST_EVICT: st_d = ST_WRITE;
      ST_WRITE: st_d = ST_DONE;
      ST_DONE:  st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // write port: refresh of a hit or insert into a free slot after the walk
  logic do_refresh;
  assign do_refresh = hit_q && (hit_exp_q ||
                      (op_q == OP_LOWER && mtu_q < hit_mtu_q) ||
                      (op_q == OP_RAISE && mtu_q > hit_mtu_q));
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_q ? hit_idx_q : free_idx_q;
    wr_data.is_v6  = v6_q;
    wr_data.key_hi = hi_q;
    wr_data.key_lo = lo_q;
    wr_data.mtu    = mtu_q;
    wr_data.stamp  = now_q;
    wr_data.life   = life_q;
    if (st_q == ST_WRITE && op_q != OP_LOOKUP && !badver_q) begin
      if (hit_q) wr_en = do_refresh;
      else wr_en = free_ok_q;
    end
  end

  // lookup answered from a live entry
  logic lk_hit;
  assign lk_hit = (op_q == OP_LOOKUP) && !badver_q && hit_q && !hit_exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      idx_q   <= '0;
      rdv_q   <= 1'b0;
      valid_q <= '0;
      fill_q  <= '0;
      out_v_q <= 1'b0;
      hit_q   <= 1'b0;
      old_ok_q <= 1'b0;
      free_ok_q <= 1'b0;
      removed_q <= '0;
    end else begin
      st_q <= st_d;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          op_q     <= in_op;
          v6_q     <= in_v6;
          badver_q <= (in_ver != VER_V4 && in_ver != VER_V6);
          hi_q     <= in_v6 ? in_hi : 64'd0;
          lo_q     <= in_v6 ? in_lo : (V4_MAP_HI | {32'd0, in_lo[31:0]});
          mtu_q    <= clamp_b;
          life_q   <= (in_ttl == 32'd0) ? def_ttl_q : in_ttl;
          now_q    <= in_now;
          idx_q    <= CW'(1);
          rdv_q    <= 1'b1;
          hit_q    <= 1'b0;
          old_ok_q <= 1'b0;
          free_ok_q <= 1'b0;
          removed_q <= '0;
        end
        ST_SCAN, ST_PURGE: begin
          if (!last_rd) idx_q <= idx_q + CW'(1);
          else rdv_q <= 1'b0;
          if (st_q == ST_SCAN) begin
            if (cur_match && !hit_q) begin
              hit_q <= 1'b1; hit_idx_q <= cur;
              hit_mtu_q <= rd_q.mtu; hit_exp_q <= cur_exp;
            end
            if (!valid_q[cur] && !free_ok_q) begin
              free_ok_q <= 1'b1; free_idx_q <= cur;
            end
            if (valid_q[cur] && cur_older) begin
              old_ok_q <= 1'b1; old_idx_q <= cur;
              old_stamp_q <= rd_q.stamp; old_rank_q <= rank_q[cur];
            end
          end else if (valid_q[cur] && cur_exp) begin
            valid_q[cur] <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
              if (valid_q[i] && rank_q[i] > rank_q[cur] && i != int'(cur))
                rank_q[i] <= rank_q[i] - IW'(1);
            fill_q <= fill_q - CW'(1);
            removed_q <= removed_q + 5'd1;
          end
        end
        ST_EVICT: begin
          valid_q[old_idx_q] <= 1'b0;
          for (int i = 0; i < ENTRIES; i++)
            if (valid_q[i] && rank_q[i] > old_rank_q)
              rank_q[i] <= rank_q[i] - IW'(1);
          fill_q <= fill_q - CW'(1);
          if (!free_ok_q) begin
            free_ok_q <= 1'b1; free_idx_q <= old_idx_q;
          end
        end
        ST_WRITE: begin
          if (op_q != OP_LOOKUP && !hit_q && free_ok_q) begin
            valid_q[free_idx_q] <= 1'b1;
            rank_q[free_idx_q]  <= fill_q[IW-1:0];
            fill_q <= fill_q + CW'(1);
          end
        end
        ST_DONE: begin
          out_v_q <= 1'b1;
          out_q   <= {4'd0, 5'(fill_q),
                      (op_q == OP_PURGE) ? removed_q : 5'd0,
                      lk_hit ? hit_mtu_q : 32'd0,
                      lk_hit,
                      badver_q && op_q != OP_PURGE};
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(32-CW){1'b0}}, fill_q} <= ENTRIES) else $error("fill over depth");
  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDLE |-> $countones(valid_q) == int'(fill_q))
    else $error("fill count mismatch");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !s_axis_tready) else $error("accept while result held");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_path_mtu_cache.sv
// ----------------------------------------------------------------------------
// tb_path_mtu_cache: self-checking bench for the path MTU cache
// Random and directed requests go through the stream ports, and the results
// are compared against a behavioral table model kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_path_mtu_cache;
  import pmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = ENTRIES;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] ttl;
    logic [63:0] now;
    logic [31:0] mtu;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [3:0]  ver;
    op_e         op;
  } req_t;

  typedef struct packed {
    logic [4:0]  total;
    logic [4:0]  removed;
    logic [31:0] mtu;
    logic        found;
    logic        status;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [263:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  path_mtu_cache DUT (.*);

  // table model state
  logic [31:0] lim_min4, lim_max4, lim_min6, lim_max6, dflt_ttl;
  logic [4:0]  cap_reg;
  logic        t_vld [NSLOT];
  logic        t_v6  [NSLOT];
  logic [63:0] t_hi  [NSLOT];
  logic [63:0] t_lo  [NSLOT];
  logic [31:0] t_mtu [NSLOT];
  logic [63:0] t_stp [NSLOT];
  logic [31:0] t_life[NSLOT];
  int          t_rank[NSLOT];
  int          t_fill;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   mismatches = 0;
  int   rsp_seen = 0;
  int   req_sent = 0;
  int   idle_cycles = 0;

  function automatic bit is_stale(int s, logic [63:0] now);
    if (now < t_stp[s]) return 1'b1;
    return (now - t_stp[s]) > {32'd0, t_life[s]};
  endfunction

  function automatic void drop_entry(int s);
    int r;
    r = t_rank[s];
    t_vld[s] = 1'b0;
    for (int i = 0; i < NSLOT; i++)
      if (t_vld[i] && t_rank[i] > r) t_rank[i]--;
    if (t_fill > 0) t_fill--;
  endfunction

  function automatic void table_reset();
    lim_min4 = 68; lim_max4 = 65535; lim_min6 = 1280; lim_max6 = 65535;
    dflt_ttl = 600000; cap_reg = 16; t_fill = 0;
    for (int i = 0; i < NSLOT; i++) t_vld[i] = 1'b0;
  endfunction

  function automatic rsp_t mtu_table_step(req_t q);
    rsp_t r;
    bit v6;
    int s, old, cap;
    logic [63:0] hi, lo;
    logic [31:0] m, life, lb, ub;
    r = '0;
    v6 = (q.ver == VER_V6);
    hi = q.hi; lo = q.lo; m = q.mtu; life = q.ttl;
    if (q.op == OP_PURGE) begin
      for (int i = 0; i < NSLOT; i++)
        if (t_vld[i] && is_stale(i, q.now)) begin
          drop_entry(i);
          r.removed++;
        end
    end else if (q.ver != VER_V4 && q.ver != VER_V6) begin
      r.status = 1'b1;
    end else begin
      if (!v6) begin
        hi = '0;
        lo = V4_MAP_HI | {32'd0, q.lo[31:0]};
      end
      s = -1;
      for (int i = 0; i < NSLOT; i++)
        if (s < 0 && t_vld[i] && t_v6[i] == v6 && t_hi[i] == hi && t_lo[i] == lo) s = i;
      if (q.op == OP_LOOKUP) begin
        if (s >= 0 && !is_stale(s, q.now)) begin
          r.found = 1'b1;
          r.mtu = t_mtu[s];
        end
      end else begin
        lb = v6 ? lim_min6 : lim_min4;
        ub = v6 ? lim_max6 : lim_max4;
        if (m < lb) m = lb;
        if (m > ub) m = ub;
        if (life == 0) life = dflt_ttl;
        if (s < 0) begin
          cap = cap_reg;
          if (cap == 0) cap = 1;
          if (cap > NSLOT) cap = NSLOT;
          if (t_fill >= cap) begin
            old = -1;
            for (int i = 0; i < NSLOT; i++)
              if (t_vld[i] && (old < 0 || t_stp[i] < t_stp[old] ||
                  (t_stp[i] == t_stp[old] && t_rank[i] < t_rank[old]))) old = i;
            if (old >= 0) drop_entry(old);
          end
          s = -1;
          for (int i = 0; i < NSLOT; i++)
            if (s < 0 && !t_vld[i]) s = i;
          if (s >= 0) begin
            t_vld[s] = 1'b1; t_v6[s] = v6; t_hi[s] = hi; t_lo[s] = lo;
            t_mtu[s] = m; t_stp[s] = q.now; t_life[s] = life;
            t_rank[s] = t_fill;
            t_fill++;
          end
        end else if (is_stale(s, q.now) || (q.op == OP_LOWER && m < t_mtu[s]) ||
                     (q.op == OP_RAISE && m > t_mtu[s])) begin
          t_mtu[s] = m; t_stp[s] = q.now; t_life[s] = life;
        end
      end
    end
    r.total = t_fill[4:0];
    return r;
  endfunction

  // append a request to the pending queue
  function automatic void add_req(req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  // driver: one request at a time with a random gap after each
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_rsps.insert(expected_rsps.size(), mtu_table_step(pending_reqs.pop_front()));
      req_sent++;
      s_axis_tvalid <= 1'b0;
      gap_left <= $urandom_range(0, 13);
    end else if (!s_axis_tvalid && rst_ni && pending_reqs.size() > 0) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else begin
        s_axis_tdata <= {2'b00, pending_reqs[0]};
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // monitor: random back-pressure, compare against oldest expectation
  int stall_left = 0;
  always @(posedge clk_i) begin
    rsp_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[43:0];
      rsp_seen++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_rsps.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: exp st=%b f=%b mtu=%0d rm=%0d n=%0d",
                      " got st=%b f=%b mtu=%0d rm=%0d n=%0d"},
                     rsp_seen, want.status, want.found, want.mtu, want.removed,
                     want.total, got.status, got.found, got.mtu, got.removed,
                     got.total);
        end
      end
      m_axis_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    end else if (rst_ni && !m_axis_tready) begin
      if (stall_left > 0) stall_left <= stall_left - 1;
      else m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_path_mtu_cache NOT OK");
      $finish;
    end
  end

  function automatic req_t make_req(op_e op, logic [3:0] ver, logic [63:0] hi,
                                    logic [63:0] lo, logic [31:0] mtu,
                                    logic [63:0] now, logic [31:0] ttl);
    req_t q;
    q.op = op; q.ver = ver; q.hi = hi; q.lo = lo; q.mtu = mtu; q.now = now; q.ttl = ttl;
    return q;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // let every queued request finish before going on
  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MIN_V4:  lim_min4 = val;
      REG_MAX_V4:  lim_max4 = val;
      REG_MIN_V6:  lim_min6 = val;
      REG_MAX_V6:  lim_max6 = val;
      REG_DEF_TTL: dflt_ttl = val;
      REG_CAP:     cap_reg = val[4:0];
      default: ;
    endcase
  endtask

  // random burst over a small key pool so hits, refreshes and evictions occur
  task automatic random_phase(int n, logic [63:0] base_time);
    logic [63:0] key_hi [8];
    logic [63:0] key_lo [8];
    logic [63:0] clock_ms;
    logic [3:0] ver;
    int k, pick;
    for (int i = 0; i < 8; i++) begin
      key_hi[i] = rand64();
      key_lo[i] = rand64();
    end
    clock_ms = base_time;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      ver = (pick < 45) ? VER_V4 : (pick < 92) ? VER_V6 : 4'($urandom);
      if ($urandom_range(0, 19) == 0) clock_ms = clock_ms - 64'($urandom_range(0, 5000));
      else clock_ms = clock_ms + 64'($urandom_range(0, 3000));
      if ($urandom_range(0, 15) == 0)
        add_req(make_req(op_e'(2'($urandom)), 4'($urandom), rand64(), rand64(),
                         $urandom, rand64(), $urandom));
      else
        add_req(make_req(op_e'(2'($urandom_range(0, 3))), ver,
          ($urandom_range(0, 3) == 0) ? rand64() : key_hi[k],
          ($urandom_range(0, 3) == 0) ? rand64() : key_lo[k],
          ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 70000),
          clock_ms,
          ($urandom_range(0, 3) == 0) ? 32'd0 :
          ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 8000)));
    end
  endtask

  initial begin
    table_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every opcode, bad versions, clamps, expiry and clock going back
    add_req(make_req(OP_LOWER, VER_V4, '1, 64'h0A00_0001, 32'd10, 64'd100, 32'd0));
    add_req(make_req(OP_LOOKUP, VER_V4, '0, 64'h0A00_0001, 32'd0, 64'd200, 32'd0));
    add_req(make_req(OP_RAISE, VER_V6, '1, '1, 32'hFFFF_FFFF, 64'd300, 32'd5));
    add_req(make_req(OP_LOOKUP, VER_V6, '1, '1, 32'd0, 64'd305, 32'd0));
    add_req(make_req(OP_LOOKUP, VER_V6, '1, '1, 32'd0, 64'd306, 32'd0));
    add_req(make_req(OP_LOOKUP, VER_V6, '1, '1, 32'd0, 64'd299, 32'd0));
    add_req(make_req(OP_LOWER, VER_V6, '0, '0, 32'd0, 64'd0, 32'hFFFF_FFFF));
    add_req(make_req(OP_RAISE, 4'd5, '1, '1, 32'd1500, '1, 32'd0));
    add_req(make_req(OP_LOOKUP, 4'hF, '0, '0, 32'd0, 64'd0, 32'd0));
    add_req(make_req(OP_RAISE, VER_V4, '0, 64'h0A00_0001, 32'd2000, 64'd400, 32'd0));
    add_req(make_req(OP_LOWER, VER_V4, '0, 64'h0A00_0001, 32'd1000, 64'd500, 32'd0));
    add_req(make_req(OP_LOOKUP, VER_V4, '0, 64'hFFFF_FFFF_0A00_0001, 32'd0, 64'd600,
                     32'd0));
    add_req(make_req(OP_PURGE, 4'hF, '1, '1, '1, 64'd50, '1));
    add_req(make_req(OP_PURGE, VER_V4, '0, '0, '0, '1, '0));
    add_req(make_req(OP_LOOKUP, VER_V4, '0, '0, 32'd0, 64'd0, 32'd0));
    drain();

    // inverted bounds, zero default lifetime, capacity of zero
    write_reg(REG_MIN_V4, 32'hFFFF_FFFF);
    write_reg(REG_MAX_V4, 32'd0);
    write_reg(REG_MIN_V6, 32'd0);
    write_reg(REG_MAX_V6, 32'hFFFF_FFFF);
    write_reg(REG_DEF_TTL, 32'd0);
    write_reg(REG_CAP, 32'd0);
    add_req(make_req(OP_RAISE, VER_V4, '0, 64'd7, 32'd1500, 64'd1000, 32'd0));
    add_req(make_req(OP_LOOKUP, VER_V4, '0, 64'd7, 32'd0, 64'd1000, 32'd0));
    add_req(make_req(OP_LOOKUP, VER_V4, '0, 64'd7, 32'd0, 64'd1001, 32'd0));
    add_req(make_req(OP_RAISE, VER_V6, '0, 64'd9, 32'd0, 64'd1000, 32'd0));
    add_req(make_req(OP_LOOKUP, VER_V6, '0, 64'd9, 32'd0, 64'd1000, 32'd0));
    random_phase(300, 64'd5000);
    drain();

    // tiny capacity, then capacity above the table size with reset IPv4 bounds
    write_reg(REG_CAP, 32'd3);
    write_reg(REG_DEF_TTL, 32'd1);
    random_phase(400, 64'hFFFF_FFFF_FFF0_0000);
    drain();
    write_reg(REG_CAP, 32'd31);
    write_reg(REG_MIN_V4, 32'd68);
    write_reg(REG_MAX_V4, 32'd65535);
    write_reg(REG_MIN_V6, 32'd1280);
    write_reg(REG_MAX_V6, 32'd9000);
    write_reg(REG_DEF_TTL, 32'hFFFF_FFFF);
    random_phase(500, 64'd0);
    drain();
    write_reg(REG_CAP, 32'd16);
    write_reg(REG_DEF_TTL, 32'd4000);
    random_phase(600, rand64());
    drain();

    $display("sent %0d requests, checked %0d results", req_sent, rsp_seen);
    $display("covered clamp bounds, lifetimes, capacities, purges and bad versions");
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("tb_path_mtu_cache OK");
    end else begin
      $display("tb_path_mtu_cache NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
